/* rtl/ssbs_pkg.sv */
// ----------------------------------------------------------------------------
// ssbs_pkg
// Shared types, codes and segment tables for the seven-segment bar serializer.
// ----------------------------------------------------------------------------
package ssbs_pkg;

	localparam int SHIFT_BITS = 32;

	localparam logic [1:0] MODE_NUMBER = 2'd0;
	localparam logic [1:0] MODE_SINGLE = 2'd1;
	localparam logic [1:0] MODE_MASK   = 2'd2;

	localparam logic [7:0] POINT_DISP1 = 8'd1;
	localparam logic [7:0] POINT_DISP2 = 8'd2;
	localparam logic [7:0] POINT_DISP3 = 8'd3;

	localparam logic [SHIFT_BITS-1:0] POINT1_BIT = 32'h8000_0000;
	localparam logic [SHIFT_BITS-1:0] POINT2_BIT = 32'h0000_0800;
	localparam logic [SHIFT_BITS-1:0] POINT3_BIT = 32'h0000_8000;

	typedef logic [SHIFT_BITS-1:0] word_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] digit_value;
		logic [3:0]  bar_level;
		logic [7:0]  point_position;
		logic [3:0]  single_led;
		logic [7:0]  led_mask;
	} cmd_item_t;

	typedef struct packed {
		logic serial_data;
		logic latch_after;
	} ser_item_t;

	function automatic logic [15:0] seg_outer(input logic [3:0] d);
		case (d)
			4'd0: seg_outer = 16'h7007;
			4'd1: seg_outer = 16'h4001;
			4'd2: seg_outer = 16'h300B;
			4'd3: seg_outer = 16'h600B;
			4'd4: seg_outer = 16'h400D;
			4'd5: seg_outer = 16'h600E;
			4'd6: seg_outer = 16'h700E;
			4'd7: seg_outer = 16'h4003;
			4'd8: seg_outer = 16'h700F;
			4'd9: seg_outer = 16'h600F;
			default: seg_outer = 16'h0000;
		endcase
	endfunction

	function automatic logic [15:0] seg_middle(input logic [3:0] d);
		case (d)
			4'd0: seg_middle = 16'h0770;
			4'd1: seg_middle = 16'h0410;
			4'd2: seg_middle = 16'h03B0;
			4'd3: seg_middle = 16'h06B0;
			4'd4: seg_middle = 16'h04D0;
			4'd5: seg_middle = 16'h06E0;
			4'd6: seg_middle = 16'h07E0;
			4'd7: seg_middle = 16'h0430;
			4'd8: seg_middle = 16'h07F0;
			4'd9: seg_middle = 16'h06F0;
			default: seg_middle = 16'h0000;
		endcase
	endfunction

	function automatic word_t bar_fill(input logic [3:0] level);
		case (level)
			4'd0: bar_fill = 32'h0000_0000;
			4'd1: bar_fill = 32'h0100_0000;
			4'd2: bar_fill = 32'h0300_0000;
			4'd3: bar_fill = 32'h0700_0000;
			4'd4: bar_fill = 32'h0F00_0000;
			4'd5: bar_fill = 32'h0F80_0000;
			4'd6: bar_fill = 32'h0FC0_0000;
			4'd7: bar_fill = 32'h0FE0_0000;
			4'd8: bar_fill = 32'h0FF0_0000;
			default: bar_fill = 32'h0000_0000;
		endcase
	endfunction

	function automatic word_t bar_single(input logic [3:0] n);
		case (n)
			4'd1: bar_single = 32'h0100_0000;
			4'd2: bar_single = 32'h0200_0000;
			4'd3: bar_single = 32'h0400_0000;
			4'd4: bar_single = 32'h0800_0000;
			4'd5: bar_single = 32'h0080_0000;
			4'd6: bar_single = 32'h0040_0000;
			4'd7: bar_single = 32'h0020_0000;
			4'd8: bar_single = 32'h0010_0000;
			default: bar_single = 32'h0000_0000;
		endcase
	endfunction

	function automatic word_t bar_mask(input logic [7:0] m);
		word_t w;
		w = '0;
		for (int i = 0; i < 8; i++) begin
			if (m[i]) begin
				w = w | bar_single(4'(i + 1));
			end
		end
		return w;
	endfunction

endpackage

/* rtl/ssbs_front.sv */
// ----------------------------------------------------------------------------
// ssbs_front
// Command intake: classifies the mode and builds the 32-bit display word,
// splitting the number into decimal digits over a short pipeline.
// ----------------------------------------------------------------------------
module ssbs_front
	import ssbs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  cmd_item_t cmd,
	output logic      word_valid,
	input  logic      word_ready,
	output word_t     word
);

	logic adv;
	logic val_s1, val_s2, val_s3, val_s4, val_s5;

	word_t base_s1, base_s2, base_s3, base_s4, base_s5;
	logic  num_s1, num_s2, num_s3, num_s4, num_s5;
	logic [15:0] v_s1;
	logic [6:0]  quo_s1;
	logic [9:0]  r_s2, r_s3;
	logic [3:0]  h_s3, h_s4, h_s5;
	logic [6:0]  rem_s4, rem_s5;
	logic [3:0]  t_s5;

	word_t       base_in;
	logic [32:0] quo_prod;
	logic [15:0] kilo;
	logic [15:0] r_full;
	logic [15:0] h_prod;
	logic [9:0]  h_scaled;
	logic [9:0]  rem_full;
	logic [14:0] t_prod;
	logic [6:0]  t_scaled;
	logic [6:0]  u_full;
	logic [3:0]  u_dig;

	assign adv       = !val_s5 || word_ready;
	assign cmd_stall = !adv;

	always_comb begin
		base_in = '0;
		case (cmd.mode)
			MODE_NUMBER: begin
				if (cmd.point_position == POINT_DISP1) begin
					base_in = POINT1_BIT;
				end else if (cmd.point_position == POINT_DISP2) begin
					base_in = POINT2_BIT;
				end else if (cmd.point_position == POINT_DISP3) begin
					base_in = POINT3_BIT;
				end
				base_in = base_in | bar_fill(cmd.bar_level);
			end
			MODE_SINGLE: base_in = bar_single(cmd.single_led);
			MODE_MASK:   base_in = bar_mask(cmd.led_mask);
			default:     base_in = '0;
		endcase
	end

	assign quo_prod = {17'd0, cmd.digit_value} * 33'd67109;
	assign kilo     = {9'd0, quo_s1} * 16'd1000;
	assign r_full   = v_s1 - kilo;
	assign h_prod   = {6'd0, r_s2} * 16'd41;
	assign h_scaled = {6'd0, h_s3} * 10'd100;
	assign rem_full = r_s3 - h_scaled;
	assign t_prod   = {8'd0, rem_s4} * 15'd205;
	assign t_scaled = {3'd0, t_s5} * 7'd10;
	assign u_full   = rem_s5 - t_scaled;
	assign u_dig    = u_full[3:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s1 <= 1'b0;
			val_s2 <= 1'b0;
			val_s3 <= 1'b0;
			val_s4 <= 1'b0;
			val_s5 <= 1'b0;
		end else if (adv) begin
			val_s1 <= cmd_valid && (cmd.mode == MODE_NUMBER || cmd.mode == MODE_SINGLE
				|| cmd.mode == MODE_MASK);
			val_s2 <= val_s1;
			val_s3 <= val_s2;
			val_s4 <= val_s3;
			val_s5 <= val_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			base_s1 <= base_in;
			num_s1  <= cmd.mode == MODE_NUMBER;
			v_s1    <= cmd.digit_value;
			quo_s1  <= quo_prod[32:26];
			base_s2 <= base_s1;
			num_s2  <= num_s1;
			r_s2    <= r_full[9:0];
			base_s3 <= base_s2;
			num_s3  <= num_s2;
			r_s3    <= r_s2;
			h_s3    <= h_prod[15:12];
			base_s4 <= base_s3;
			num_s4  <= num_s3;
			h_s4    <= h_s3;
			rem_s4  <= rem_full[6:0];
			base_s5 <= base_s4;
			num_s5  <= num_s4;
			h_s5    <= h_s4;
			rem_s5  <= rem_s4;
			t_s5    <= t_prod[14:11];
		end
	end

	assign word_valid = val_s5;
	assign word = num_s5
		? (base_s5 | {seg_outer(h_s5), 16'h0000} | {16'h0000, seg_middle(t_s5)}
			| {16'h0000, seg_outer(u_dig)})
		: base_s5;

	property p_hold_blocked;
		@(posedge clk) disable iff (!arst_n)
		val_s5 && !word_ready |=> val_s5 && $stable(word);
	endproperty
	a_hold_blocked: assert property (p_hold_blocked)
		else $error("front word changed while blocked");

endmodule

/* rtl/ssbs_queue.sv */
// ----------------------------------------------------------------------------
// ssbs_queue
// Small word queue between the command front and the bit shifter.
// ----------------------------------------------------------------------------
module ssbs_queue
	import ssbs_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  word_t push_word,
	output logic  pop_valid,
	input  logic  pop_take,
	output word_t pop_word
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	word_t            entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = count_q != CNT_FULL;
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_take && pop_valid;
	assign pop_word   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_word;
		end
	end

	property p_count_bound;
		@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL;
	endproperty
	a_count_bound: assert property (p_count_bound)
		else $error("queue count beyond depth");

	property p_no_underflow;
		@(posedge clk) disable iff (!arst_n)
		pop_take |-> count_q != '0;
	endproperty
	a_no_underflow: assert property (p_no_underflow)
		else $error("queue popped while empty");

endmodule

/* rtl/ssbs_back.sv */
// ----------------------------------------------------------------------------
// ssbs_back
// Bit shifter: sends each queued word LSB first, one transaction per bit,
// and marks the last bit for the latch.
// ----------------------------------------------------------------------------
module ssbs_back
	import ssbs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      word_valid,
	output logic      word_take,
	input  word_t     word,
	output logic      ser_valid,
	input  logic      ser_stall,
	output ser_item_t ser
);

	localparam int CNT_W = $clog2(SHIFT_BITS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SHIFT_BITS - 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	word_t            shift_q;
	logic             last;
	logic             load;

	assign last      = cnt_q == CNT_LAST;
	assign load      = word_valid && (!busy_q || (!ser_stall && last));
	assign word_take = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q && !ser_stall) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			shift_q <= word;
		end else if (busy_q && !ser_stall) begin
			shift_q <= {1'b0, shift_q[SHIFT_BITS-1:1]};
		end
	end

	assign ser_valid       = busy_q;
	assign ser.serial_data = shift_q[0];
	assign ser.latch_after = last;

	property p_word_continues;
		@(posedge clk) disable iff (!arst_n)
		busy_q && !ser_stall && !last |=> busy_q && cnt_q == $past(cnt_q) + 1'b1;
	endproperty
	a_word_continues: assert property (p_word_continues)
		else $error("bit sequence broken before latch");

	property p_load_only_free;
		@(posedge clk) disable iff (!arst_n)
		load |-> !busy_q || last;
	endproperty
	a_load_only_free: assert property (p_load_only_free)
		else $error("new word loaded mid-sequence");

endmodule

/* rtl/seven_segment_bar_serializer.sv */
// ----------------------------------------------------------------------------
// seven_segment_bar_serializer
// Builds a 32-bit shift-register word per command and sends it out serially.
// ----------------------------------------------------------------------------
// Each command yields 32 output transactions, one word bit each, LSB first;
// latch_after is high on the 32nd. The bit shifter sends one bit per clock
// while ser_stall is low, and loads the next queued word as the last bit of
// the current one goes out. A command passes the five-stage digit pipeline,
// the word queue and the bit shifter. Commands with mode 3 are taken and
// produce nothing. The word queue of QUEUE_DEPTH entries lets new commands
// enter while the current word is still being shifted out.
module seven_segment_bar_serializer
	import ssbs_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  cmd_item_t cmd,
	output logic      ser_valid,
	input  logic      ser_stall,
	output ser_item_t ser
);

	logic  fr_valid;
	logic  fr_ready;
	word_t fr_word;
	logic  qu_valid;
	logic  qu_take;
	word_t qu_word;

	ssbs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.word_valid(fr_valid),
		.word_ready(fr_ready),
		.word      (fr_word)
	);

	ssbs_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(fr_valid),
		.push_ready(fr_ready),
		.push_word (fr_word),
		.pop_valid (qu_valid),
		.pop_take  (qu_take),
		.pop_word  (qu_word)
	);

	ssbs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.word_valid(qu_valid),
		.word_take (qu_take),
		.word      (qu_word),
		.ser_valid (ser_valid),
		.ser_stall (ser_stall),
		.ser       (ser)
	);

endmodule
